FILE: sv/cabbe_pkg.sv
package cabbe_pkg;

    localparam int CHAR_BITS_DEFAULT = 16;
    localparam int CHAR_W            = 16;

    localparam logic [CHAR_W-1:0] CHAR_LBRACE   = 16'h007B;
    localparam logic [CHAR_W-1:0] CHAR_RBRACE   = 16'h007D;
    localparam logic [CHAR_W-1:0] CHAR_SLASH    = 16'h002F;
    localparam logic [CHAR_W-1:0] CHAR_STAR     = 16'h002A;
    localparam logic [CHAR_W-1:0] CHAR_QUESTION = 16'h003F;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 16'h000A;

    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [2:0] {
        ST_DATA       = 3'd0,
        ST_CLOSED     = 3'd1,
        ST_NO_BLOCK   = 3'd2,
        ST_NOT_BRACE  = 3'd3,
        ST_NON_LATIN1 = 3'd4,
        ST_UNTERM     = 3'd5
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              in_comment;
        status_t           status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic in_block;
        logic in_line_comment;
        logic in_star_comment;
        logic closing_star_seen;
        logic slash_pending;
    } flags_t;

    localparam result_t RESULT_NONE = '{out_char: '0, in_comment: 1'b0,
                                        status: ST_DATA, last: 1'b0};

endpackage

FILE: sv/comment_aware_brace_block_extractor.sv
// Brace block extractor with C-style comment tracking.
// Input channel: in_valid/in_stall carry one word (cmd, ch); cmd 0 is a
// character, cmd 1 marks end of text. A word is taken when in_valid is high
// and in_stall is low.
// Output channel: out_valid/out_stall carry result words (out_char,
// in_comment, status, last); last marks the final result of an input word.
// Configuration: cfg_valid/cfg_ready write byte_mode; cfg_ready is always
// high. Write only while the block is idle.
// Path: a taken word sits in the input register, is decoded combinationally
// and its results are written into the three-entry queue that drives the output.
// Throughput: one word per cycle while each word yields at most one result
// and the receiver keeps up; a word that yields two results can fill the queue
// and stall the input, as the single result port drains it one result at a time.
// Reset: byte_mode returns to 1, all tracking flags clear (waiting for '{'),
// input register and result queue are emptied.
// Receiver stall: the queue holds its words; once it cannot take the next
// word's results the input register holds and in_stall rises.
module comment_aware_brace_block_extractor #(
    parameter int CHAR_BITS = cabbe_pkg::CHAR_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [15:0]            ch,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [15:0]            out_char,
    output logic                   in_comment,
    output cabbe_pkg::status_t     status,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   byte_mode
);
    import cabbe_pkg::*;

    localparam logic [15:0] CHAR_MASK =
        (CHAR_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << CHAR_BITS) - 17'd1);

    logic              in_valid_reg;
    logic              cmd_reg;
    logic [15:0]       ch_reg;
    logic              byte_mode_reg;
    flags_t            flags_reg;
    flags_t            flags_next;
    result_t           q_reg [QUEUE_DEPTH];
    result_t           q_next [QUEUE_DEPTH];
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [1:0]        cnt_after;
    logic [1:0]        n_results;
    result_t           res0;
    result_t           res1;
    logic              pop;
    logic              advance;

    cabbe_step u_step (
        .cmd        (cmd_reg),
        .ch         (ch_reg),
        .byte_mode  (byte_mode_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .n_results  (n_results),
        .res0       (res0),
        .res1       (res1)
    );

    assign pop       = (cnt_reg != 2'd0) && !out_stall;
    assign cnt_after = cnt_reg - {1'b0, pop};
    assign advance   = in_valid_reg &&
                       (({1'b0, cnt_after} + {1'b0, n_results}) <= 3'(QUEUE_DEPTH));
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign out_valid  = (cnt_reg != 2'd0);
    assign out_char   = q_reg[0].out_char;
    assign in_comment = q_reg[0].in_comment;
    assign status     = q_reg[0].status;
    assign last       = q_reg[0].last;

    // shift out the head, then append this word's results behind what stays
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (advance && n_results != 2'd0 && 2'(i) == cnt_after) begin
                q_next[i] = res0;
            end
            if (advance && n_results == 2'd2 && 3'(i) == ({1'b0, cnt_after} + 3'd1)) begin
                q_next[i] = res1;
            end
        end
        cnt_next = advance ? 2'(cnt_after + n_results) : cnt_after;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            byte_mode_reg <= 1'b1;
            flags_reg     <= '0;
            cnt_reg       <= 2'd0;
        end else begin
            if (!in_stall) begin
                in_valid_reg <= in_valid;
            end
            if (cfg_valid && cfg_ready) begin
                byte_mode_reg <= byte_mode;
            end
            if (advance) begin
                flags_reg <= flags_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && !in_stall) begin
            cmd_reg <= cmd;
            ch_reg  <= ch & CHAR_MASK;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

FILE: sv/cabbe_step.sv
module cabbe_step (
    input  logic                      cmd,
    input  logic [15:0]               ch,
    input  logic                      byte_mode,
    input  cabbe_pkg::flags_t         flags,
    output cabbe_pkg::flags_t         flags_next,
    output logic [1:0]                n_results,
    output cabbe_pkg::result_t        res0,
    output cabbe_pkg::result_t        res1
);
    import cabbe_pkg::*;

    typedef struct packed {
        result_t r;
        logic    hold;
        logic    to_idle;
    } plain_t;

    logic bad;

    assign bad = byte_mode && ((ch == '0) || (ch[15:8] != 8'd0));

    // Character outside any comment: hold a slash, reject bad bytes, close on brace, pass the rest.
    function automatic plain_t plain_char(input logic [15:0] c, input logic is_bad);
        plain_t p;
        p = '{r: RESULT_NONE, hold: 1'b0, to_idle: 1'b0};
        if (c == CHAR_SLASH) begin
            p.hold = 1'b1;
        end else if (is_bad) begin
            p.r.status = ST_NON_LATIN1;
            p.to_idle  = 1'b1;
        end else if (c == CHAR_RBRACE) begin
            p.r.status = ST_CLOSED;
            p.to_idle  = 1'b1;
        end else begin
            p.r.out_char = c;
        end
        return p;
    endfunction

    always_comb begin
        plain_t  p;
        result_t cm;
        result_t sl;

        p  = plain_char(ch, bad);
        cm = RESULT_NONE;
        cm.out_char   = bad ? CHAR_QUESTION : ch;
        cm.in_comment = 1'b1;
        sl = RESULT_NONE;
        sl.out_char = CHAR_SLASH;

        flags_next = flags;
        n_results  = 2'd0;
        res0       = RESULT_NONE;
        res1       = RESULT_NONE;

        if (!flags.in_block) begin
            if (cmd) begin
                res0.status = ST_NO_BLOCK;
                n_results   = 2'd1;
            end else if (ch == CHAR_LBRACE) begin
                flags_next          = '0;
                flags_next.in_block = 1'b1;
            end else begin
                res0.status = ST_NOT_BRACE;
                n_results   = 2'd1;
            end
        end else if (cmd) begin
            // flush a held slash ahead of the unterminated report
            if (flags.slash_pending) begin
                res0        = sl;
                res1.status = ST_UNTERM;
                n_results   = 2'd2;
            end else begin
                res0.status = ST_UNTERM;
                n_results   = 2'd1;
            end
            flags_next = '0;
        end else if (flags.slash_pending) begin
            flags_next.slash_pending = 1'b0;
            if (ch == CHAR_STAR || ch == CHAR_SLASH) begin
                res0            = sl;
                res0.in_comment = 1'b1;
                res1            = RESULT_NONE;
                res1.out_char   = ch;
                res1.in_comment = 1'b1;
                n_results       = 2'd2;
                if (ch == CHAR_STAR) begin
                    flags_next.in_star_comment   = 1'b1;
                    flags_next.closing_star_seen = 1'b0;
                end else begin
                    flags_next.in_line_comment = 1'b1;
                end
            end else begin
                res0 = sl;
                if (p.hold) begin
                    flags_next.slash_pending = 1'b1;
                    n_results                = 2'd1;
                end else begin
                    res1      = p.r;
                    n_results = 2'd2;
                    if (p.to_idle) begin
                        flags_next = '0;
                    end
                end
            end
        end else if (flags.in_line_comment) begin
            res0      = cm;
            n_results = 2'd1;
            if (ch == CHAR_NEWLINE) begin
                flags_next.in_line_comment = 1'b0;
            end
        end else if (flags.in_star_comment) begin
            res0      = cm;
            n_results = 2'd1;
            if (flags.closing_star_seen && ch == CHAR_SLASH) begin
                flags_next.in_star_comment   = 1'b0;
                flags_next.closing_star_seen = 1'b0;
            end else begin
                flags_next.closing_star_seen = (ch == CHAR_STAR);
            end
        end else begin
            if (p.hold) begin
                flags_next.slash_pending = 1'b1;
            end else begin
                res0      = p.r;
                n_results = 2'd1;
                if (p.to_idle) begin
                    flags_next = '0;
                end
            end
        end

        if (n_results == 2'd1) begin
            res0.last = 1'b1;
        end
        if (n_results == 2'd2) begin
            res1.last = 1'b1;
        end
    end

endmodule

FILE: sim/comment_aware_brace_block_extractor_tb.sv
module comment_aware_brace_block_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cabbe_pkg::*;

    localparam int RANDOM_ITEMS = 2000;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              cmd        = 1'b0;
    logic [15:0]       ch         = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [15:0]       out_char;
    logic              in_comment;
    status_t           status;
    logic              last;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic              byte_mode  = 1'b1;

    // predicted state of the extractor
    logic latin1_mode = 1'b1;
    logic body_open   = 1'b0;
    logic line_cmt    = 1'b0;
    logic star_cmt    = 1'b0;
    logic star_seen   = 1'b0;
    logic slash_held  = 1'b0;

    result_t pending_results[$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      send_level  = 2;
    int      recv_level  = 2;
    int      hold_cycles = 0;

    comment_aware_brace_block_extractor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .ch         (ch),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .in_comment (in_comment),
        .status     (status),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .byte_mode  (byte_mode)
    );

    always #10 clk = ~clk;

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // level 0: never wait, 1: wait now and then, 2: draw a wait before every word
    function automatic int draw_wait(input int level);
        if (level == 0)
            return 0;
        if (level == 1)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] pick_char();
        case ($urandom_range(0, 39))
            0:           return CHAR_RBRACE;
            1, 2, 3, 4:  return CHAR_SLASH;
            5, 6, 7:     return CHAR_STAR;
            8, 9:        return CHAR_NEWLINE;
            10:          return 16'h0000;
            11, 12:      return 16'($urandom_range(256, 65535));
            13, 14:      return 16'($urandom);
            15:          return CHAR_LBRACE;
            16, 17:      return 16'($urandom_range(128, 255));
            default:     return 16'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic logic is_bad_byte(input logic [15:0] c);
        return latin1_mode && (c == 16'h0000 || c > 16'h00FF);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_result(input logic [15:0] c, input logic cm, input status_t st);
        result_t r;
        r.out_char   = c;
        r.in_comment = cm;
        r.status     = st;
        r.last       = 1'b0;
        pending_results.push_back(r);
    endtask

    task automatic clear_flags;
        body_open  = 1'b0;
        line_cmt   = 1'b0;
        star_cmt   = 1'b0;
        star_seen  = 1'b0;
        slash_held = 1'b0;
    endtask

    task automatic code_char(input logic [15:0] c);
        if (c == CHAR_SLASH)
            slash_held = 1'b1;
        else if (is_bad_byte(c))
        begin
            clear_flags();
            push_result('0, 1'b0, ST_NON_LATIN1);
        end
        else if (c == CHAR_RBRACE)
        begin
            clear_flags();
            push_result('0, 1'b0, ST_CLOSED);
        end
        else
            push_result(c, 1'b0, ST_DATA);
    endtask

    // work out the result words of one accepted input word
    task automatic extract_step(input logic is_end, input logic [15:0] c);
        int      n0;
        result_t r;
        n0 = pending_results.size();
        if (!body_open)
        begin
            if (is_end)
                push_result('0, 1'b0, ST_NO_BLOCK);
            else if (c == CHAR_LBRACE)
            begin
                clear_flags();
                body_open = 1'b1;
            end
            else
                push_result('0, 1'b0, ST_NOT_BRACE);
        end
        else if (is_end)
        begin
            if (slash_held)
                push_result(CHAR_SLASH, 1'b0, ST_DATA);
            clear_flags();
            push_result('0, 1'b0, ST_UNTERM);
        end
        else if (slash_held)
        begin
            slash_held = 1'b0;
            if (c == CHAR_STAR || c == CHAR_SLASH)
            begin
                push_result(CHAR_SLASH, 1'b1, ST_DATA);
                push_result(c, 1'b1, ST_DATA);
                if (c == CHAR_STAR)
                begin
                    star_cmt  = 1'b1;
                    star_seen = 1'b0;
                end
                else
                    line_cmt = 1'b1;
            end
            else
            begin
                push_result(CHAR_SLASH, 1'b0, ST_DATA);
                code_char(c);
            end
        end
        else if (line_cmt)
        begin
            push_result(is_bad_byte(c) ? CHAR_QUESTION : c, 1'b1, ST_DATA);
            if (c == CHAR_NEWLINE)
                line_cmt = 1'b0;
        end
        else if (star_cmt)
        begin
            push_result(is_bad_byte(c) ? CHAR_QUESTION : c, 1'b1, ST_DATA);
            if (star_seen && c == CHAR_SLASH)
            begin
                star_cmt  = 1'b0;
                star_seen = 1'b0;
            end
            else
                star_seen = (c == CHAR_STAR);
        end
        else
            code_char(c);

        if (pending_results.size() > n0)
        begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    task automatic check_result;
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word char=%h status=%0d",
                                      out_char, status));
            return;
        end
        want = pending_results.pop_front();
        if (out_char !== want.out_char || in_comment !== want.in_comment ||
            status !== want.status || last !== want.last)
            report_mismatch($sformatf(
                "got char=%h cmt=%b st=%0d last=%b, want char=%h cmt=%b st=%0d last=%b",
                out_char, in_comment, status, last,
                want.out_char, want.in_comment, want.status, want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
    end

    // receiver: may stall before each word, or for a long hold when asked
    initial
    begin
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = draw_wait(recv_level);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1 && hold_cycles == 0);
        end
    end

    // returns at the edge that takes the word; valid stays up for a back-to-back word
    task automatic send_word(input logic is_end, input logic [15:0] c);
        int gap;
        gap = draw_wait(send_level);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= is_end;
        ch       <= c;
        do
            @(posedge clk);
        while (in_stall);
        extract_step(is_end, c);
        items_sent++;
    endtask

    task automatic send_char(input logic [15:0] c);
        send_word(1'b0, c);
    endtask

    task automatic send_end;
        send_word(1'b1, 16'($urandom));
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // words that give no result may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        cfg_valid <= 1'b1;
        byte_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        latin1_mode = m;
    endtask

    task automatic test_idle_errors;
        send_level = 2;
        recv_level = 2;
        send_end();
        send_char(16'h0061);
        wait_idle();
    endtask

    task automatic test_comment_tracking;
        send_level = 1;
        recv_level = 1;
        send_char(CHAR_LBRACE);
        // the opening star must not close the comment
        send_char(CHAR_SLASH);
        send_char(CHAR_STAR);
        send_char(CHAR_SLASH);
        send_char(16'hFFFF);
        send_char(16'h0000);
        send_char(CHAR_STAR);
        send_char(CHAR_SLASH);
        // brace inside a line comment is plain text
        send_char(CHAR_SLASH);
        send_char(CHAR_SLASH);
        send_char(CHAR_RBRACE);
        send_char(CHAR_NEWLINE);
        send_char(CHAR_RBRACE);
        wait_idle();
    endtask

    task automatic test_held_slash;
        send_level = 0;
        recv_level = 2;
        send_char(CHAR_LBRACE);
        send_char(CHAR_SLASH);
        send_char(16'h0062);
        send_char(CHAR_SLASH);
        send_char(CHAR_STAR);
        send_end();
        send_char(CHAR_LBRACE);
        send_char(CHAR_SLASH);
        send_char(CHAR_RBRACE);
        send_char(CHAR_LBRACE);
        send_char(CHAR_SLASH);
        send_end();
        wait_idle();
    endtask

    task automatic test_byte_mode;
        send_level = 2;
        recv_level = 0;
        send_char(CHAR_LBRACE);
        send_char(16'h0100);
        set_mode(1'b0);
        send_char(CHAR_LBRACE);
        send_char(16'h0000);
        send_char(16'hFFFF);
        send_char(CHAR_SLASH);
        send_char(CHAR_SLASH);
        send_char(16'h1234);
        send_end();
        set_mode(1'b1);
    endtask

    task automatic test_backpressure;
        send_level  = 0;
        recv_level  = 0;
        hold_cycles = 300;
        send_char(CHAR_LBRACE);
        repeat (60) send_char(16'($urandom_range(32, 122)));
        send_char(CHAR_RBRACE);
        wait_idle();
    endtask

    task automatic send_random_block;
        int n;
        int kind;
        // noise while waiting for a brace
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 2) == 0)
                    send_end();
                else
                    send_char(pick_char());
            end
        end
        send_char(CHAR_LBRACE);
        n = $urandom_range(0, 20);
        repeat (n)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                send_char(CHAR_SLASH);
                send_char(CHAR_STAR);
                repeat ($urandom_range(0, 6)) send_char(pick_char());
                if ($urandom_range(0, 5) != 0)
                begin
                    send_char(CHAR_STAR);
                    send_char(CHAR_SLASH);
                end
            end
            else if (kind == 1)
            begin
                send_char(CHAR_SLASH);
                send_char(CHAR_SLASH);
                repeat ($urandom_range(0, 6)) send_char(pick_char());
                if ($urandom_range(0, 5) != 0)
                    send_char(CHAR_NEWLINE);
            end
            else
                send_char(pick_char());
        end
        kind = $urandom_range(0, 19);
        if (kind < 15)
            send_char(CHAR_RBRACE);
        else if (kind < 19)
            send_end();
    endtask

    task automatic test_random;
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            send_level = $urandom_range(0, 2);
            recv_level = $urandom_range(0, 2);
            repeat ($urandom_range(3, 10)) send_random_block();
            if ($urandom_range(0, 5) == 0)
            begin
                // leave the body before switching modes
                send_end();
                set_mode(1'($urandom_range(0, 1)));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_errors();
        test_comment_tracking();
        test_held_slash();
        test_byte_mode();
        test_backpressure();
        test_random();

        in_valid <= 1'b0;
        for (i = 0; i < 5000 && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected words never came",
                                      pending_results.size()));

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
